FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the LED pattern sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

FILE: src/slps_pkg.sv
`default_nettype none

package slps_pkg;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_MODE   = 3'd1,
    CMD_SET_JOINED = 3'd2,
    CMD_FLASH      = 3'd3,
    CMD_ERROR      = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_BOOT        = 3'd0,
    MODE_JOINING     = 3'd1,
    MODE_REJOINING   = 3'd2,
    MODE_JOINED      = 3'd3,
    MODE_IDENTIFYING = 3'd4,
    MODE_RESET_HOLD  = 3'd5,
    MODE_FACTORY     = 3'd6,
    MODE_ERROR       = 3'd7
  } mode_t;

  // Register indexes, taken from paddr[2].
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_LEVEL  = 1'b1;

  localparam logic [3:0] ERR_BLINK_LEN = 4'd12;
  localparam logic [1:0] FLASH_LEN     = 2'd2;

  localparam logic [7:0] LVL_FULL  = 8'd48;
  localparam logic [7:0] LVL_BLUE  = 8'd32;
  localparam logic [7:0] LVL_ORNG  = 8'd28;
  localparam logic [7:0] LVL_DIM   = 8'd12;
  localparam logic [7:0] LVL_IDLE  = 8'd18;
  localparam logic [7:0] LVL_FAINT = 8'd3;
  localparam logic [7:0] LVL_MAX   = 8'hff;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic valid;
    rgb_t color;
  } stage_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] level;
  } cfg_t;

endpackage

`default_nettype wire

FILE: src/slps_cmd_if.sv
`default_nettype none

interface slps_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [2:0] mode;
  logic       switch_state;

  modport source (output valid, cmd, mode, switch_state, input ready);
  modport sink (input valid, cmd, mode, switch_state, output ready);
endinterface

`default_nettype wire

FILE: src/slps_led_if.sv
`default_nettype none

interface slps_led_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

FILE: src/slps_cfg.sv
`default_nettype none

module slps_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output slps_pkg::cfg_t     cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b1;
      cfg.level  <= slps_pkg::LVL_MAX;
    end else if (wr_en) begin
      unique case (paddr[2])
        slps_pkg::REG_ENABLE: cfg.enable <= pwdata[0];
        slps_pkg::REG_LEVEL:  cfg.level  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[2])
      slps_pkg::REG_ENABLE: prdata = {31'd0, cfg.enable};
      slps_pkg::REG_LEVEL:  prdata = {24'd0, cfg.level};
      default: prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/slps_ctrl.sv
`default_nettype none

module slps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       cmd,
  input  logic [2:0]       mode,
  input  logic             switch_state,
  input  logic             out_free,
  output slps_pkg::stage_t stage
);

  slps_pkg::mode_t current_mode, current_mode_next;
  logic            output_flag, output_flag_next;
  logic [1:0]      flash_count, flash_count_next;
  logic [3:0]      error_count, error_count_next;
  logic [2:0]      tick_phase, tick_phase_next;

  logic            stage_valid;
  slps_pkg::rgb_t  stage_color;
  slps_pkg::rgb_t  color;
  logic            in_fire;
  logic            is_tick;
  logic            even;
  logic [3:0]      err_phase;

  // The colour stage moves on whenever the scaling stage has room.
  assign in_ready = !stage_valid || out_free;
  assign in_fire  = in_valid && in_ready;
  assign is_tick  = (cmd == slps_pkg::CMD_TICK);
  assign stage    = '{valid: stage_valid, color: stage_color};

  assign even      = !tick_phase[0];
  assign err_phase = slps_pkg::ERR_BLINK_LEN - error_count;

  // Colour seen by a tick, taken from the state before the tick updates it.
  always_comb begin
    color = '0;
    if (error_count != 4'd0) begin
      if (!err_phase[1]) color.red = slps_pkg::LVL_FULL;
    end else if (flash_count != 2'd0) begin
      color.green = slps_pkg::LVL_FULL;
      color.blue  = slps_pkg::LVL_FULL;
    end else begin
      unique case (current_mode)
        slps_pkg::MODE_JOINING: begin
          if (even) color.blue = slps_pkg::LVL_BLUE;
        end
        slps_pkg::MODE_REJOINING: begin
          if (!tick_phase[1]) begin
            color.red   = slps_pkg::LVL_ORNG;
            color.green = slps_pkg::LVL_DIM;
          end
        end
        slps_pkg::MODE_JOINED: begin
          if (output_flag) color.green = slps_pkg::LVL_FULL;
          else if (tick_phase == 3'd0) color.green = slps_pkg::LVL_IDLE;
          else color.green = slps_pkg::LVL_FAINT;
        end
        slps_pkg::MODE_IDENTIFYING: begin
          if (even) begin
            color.red   = slps_pkg::LVL_FULL;
            color.green = slps_pkg::LVL_FULL;
          end
        end
        slps_pkg::MODE_RESET_HOLD: begin
          if (even) begin
            color.red   = slps_pkg::LVL_FULL;
            color.green = slps_pkg::LVL_DIM;
          end
        end
        slps_pkg::MODE_FACTORY: begin
          if (even) begin
            color.red  = slps_pkg::LVL_FULL;
            color.blue = slps_pkg::LVL_FULL;
          end
        end
        slps_pkg::MODE_ERROR: begin
          if (even) color.red = slps_pkg::LVL_FULL;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    current_mode_next = current_mode;
    output_flag_next  = output_flag;
    flash_count_next  = flash_count;
    error_count_next  = error_count;
    tick_phase_next   = tick_phase;
    if (in_fire) begin
      unique case (cmd)
        slps_pkg::CMD_TICK: begin
          if (error_count != 4'd0) error_count_next = error_count - 4'd1;
          else if (flash_count != 2'd0) flash_count_next = flash_count - 2'd1;
          tick_phase_next = tick_phase + 3'd1;
        end
        slps_pkg::CMD_SET_MODE: begin
          current_mode_next = slps_pkg::mode_t'(mode);
        end
        slps_pkg::CMD_SET_JOINED: begin
          current_mode_next = slps_pkg::MODE_JOINED;
          output_flag_next  = switch_state;
        end
        slps_pkg::CMD_FLASH: begin
          current_mode_next = slps_pkg::MODE_JOINED;
          output_flag_next  = switch_state;
          flash_count_next  = slps_pkg::FLASH_LEN;
          error_count_next  = 4'd0;
        end
        slps_pkg::CMD_ERROR: begin
          flash_count_next = 2'd0;
          error_count_next = slps_pkg::ERR_BLINK_LEN;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= slps_pkg::MODE_BOOT;
      output_flag  <= 1'b0;
      flash_count  <= 2'd0;
      error_count  <= 4'd0;
      tick_phase   <= 3'd0;
      stage_valid  <= 1'b0;
    end else begin
      current_mode <= current_mode_next;
      output_flag  <= output_flag_next;
      flash_count  <= flash_count_next;
      error_count  <= error_count_next;
      tick_phase   <= tick_phase_next;
      if (in_ready) stage_valid <= in_fire && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) stage_color <= color;
  end

endmodule

`default_nettype wire

FILE: src/slps_scale.sv
`default_nettype none

module slps_scale (
  input  logic             clk,
  input  logic             rst,
  input  slps_pkg::stage_t stage,
  input  slps_pkg::cfg_t   cfg,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output slps_pkg::rgb_t   out_color
);

  slps_pkg::rgb_t scaled;

  // c * level / 255: with x = 256*t + low, the remainder low + t stays
  // below 510, so one compare fixes the quotient t.
  function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [7:0] level);
    logic [15:0] prod;
    logic [7:0]  quo;
    logic [8:0]  rem;
    prod = {8'd0, c} * {8'd0, level};
    quo  = prod[15:8];
    rem  = {1'b0, prod[7:0]} + {1'b0, quo};
    if (rem >= {1'b0, slps_pkg::LVL_MAX}) quo = quo + 8'd1;
    return quo;
  endfunction

  always_comb begin
    scaled = '0;
    if (cfg.enable) begin
      scaled.red   = scale_ch(stage.color.red, cfg.level);
      scaled.green = scale_ch(stage.color.green, cfg.level);
      scaled.blue  = scale_ch(stage.color.blue, cfg.level);
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) out_color <= scaled;
  end

endmodule

`default_nettype wire

FILE: src/status_led_pattern_sequencer.sv
// Status LED pattern sequencer.
// A tick's colour passes the colour register and then the scaling register;
// other commands update state at acceptance and give no output.
// Throughput: one transaction per cycle unless leds.ready stalls both registers.
// Reset (rst, synchronous): boot mode, all counters zero, light enabled at full level.
`default_nettype none
`include "assert_macros.svh"

module status_led_pattern_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  slps_cmd_if.sink    events,
  slps_led_if.source  leds
);

  slps_pkg::cfg_t   cfg;
  slps_pkg::stage_t stage;
  slps_pkg::rgb_t   out_color;
  logic             out_free;
  logic             in_fire;

  slps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (events.valid),
    .in_ready     (events.ready),
    .cmd          (events.cmd),
    .mode         (events.mode),
    .switch_state (events.switch_state),
    .out_free     (out_free),
    .stage        (stage)
  );

  slps_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .cfg       (cfg),
    .out_free  (out_free),
    .out_valid (leds.valid),
    .out_ready (leds.ready),
    .out_color (out_color)
  );

  assign leds.red   = out_color.red;
  assign leds.green = out_color.green;
  assign leds.blue  = out_color.blue;

  assign in_fire = events.valid && events.ready;

  `ASSERT_NEXT(a_cmd_no_color, clk, rst, in_fire && events.cmd != slps_pkg::CMD_TICK, !stage.valid)
  `ASSERT_NEXT(a_tick_color, clk, rst, in_fire && events.cmd == slps_pkg::CMD_TICK, stage.valid)
  `ASSERT_NEXT(a_stage_hold, clk, rst, stage.valid && !out_free, stage.valid && $stable(stage.color))
  `ASSERT_SAME(a_stall_no_accept, clk, rst, stage.valid && !out_free, !events.ready)

endmodule

`default_nettype wire
